[rtl/core/utf8d_pkg.sv]
// Package for the UTF-8 to UTF-32 stream decoder.
// Holds register indexes, lead-byte decode, excess constants and word swap.
// No dependencies.
package utf8d_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_SWAP_OUTPUT = 1'b0,
      CSR_MAX_WORDS   = 1'b1
   } csr_index_type;

   localparam int unsigned CSR_DATA_W = 16;

   // Excess removed from the accumulated sum, by sequence length minus one
   localparam logic [31:0] EXCESS_2 = (32'h0C0 << 6) | 32'h080;
   localparam logic [31:0] EXCESS_3 = (32'h0E0 << 12) | (32'h080 << 6) | 32'h080;
   localparam logic [31:0] EXCESS_4 = (32'h0F0 << 18) | (32'h080 << 12) |
                                      (32'h080 << 6) | 32'h080;

   // Continuation bytes announced by a lead byte; F0..FF split by low nibble
   function automatic logic [2:0] follow_count(input logic [7:0] b);
      logic [2:0] n;
      if (b inside {[8'h00:8'hBF]}) begin
         n = 3'd0;
      end else if (b inside {[8'hC0:8'hDF]}) begin
         n = 3'd1;
      end else if (b inside {[8'hE0:8'hEF]}) begin
         n = 3'd2;
      end else if (b[3] == 1'b0) begin
         n = 3'd3;
      end else if (b[2] == 1'b0) begin
         n = 3'd4;
      end else begin
         n = 3'd5;
      end
      return n;
   endfunction

   function automatic logic [31:0] excess(input logic [1:0] idx);
      logic [31:0] e;
      case (idx)
         2'd0:    e = 32'd0;
         2'd1:    e = EXCESS_2;
         2'd2:    e = EXCESS_3;
         2'd3:    e = EXCESS_4;
         default: e = 32'd0;
      endcase
      return e;
   endfunction

   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

[rtl/core/utf8_to_utf32_decoder.sv]
// UTF-8 to UTF-32 stream decoder, top level.
// Depends on utf8d_pkg.
//
// Takes one UTF-8 byte per cycle, sustained: each byte is decoded by one
// shallow step between the buffer state registers and the result register,
// and a new byte is accepted in every cycle in which the result register is
// free or its transfer completes. The result for a byte that completes a
// nonzero code point or carries last is registered. Byte counts and word
// counts are COUNT_BITS wide, reported as their low 16 bits with last.
// No clearing pass after reset; the CSR port is always ready.
module utf8_to_utf32_decoder #(
   parameter int unsigned COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_last,
   // word output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_code_point,
   output logic                              rsp_point_valid,
   output logic                              rsp_end_report,
   output logic [15:0]                       rsp_consumed_count,
   output logic [15:0]                       rsp_words_written,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  utf8d_pkg::csr_index_type          csr_index,
   input  logic [utf8d_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import utf8d_pkg::*;

   localparam int unsigned EXT_W = COUNT_BITS + 16;

   // Configuration registers
   logic        swap_ff;
   logic [15:0] max_words_ff;

   // Buffer state
   logic [2:0]            pending_ff,   pending_in;
   logic [2:0]            seq_len_ff,   seq_len_in;
   logic [31:0]           acc_ff,       acc_in;
   logic                  discard_ff,   discard_in;
   logic                  halted_ff,    halted_in;
   logic [COUNT_BITS-1:0] consumed_ff,  consumed_in;
   logic [COUNT_BITS-1:0] words_ff,     words_in;

   // Result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] cp_ff,        cp_in;
   logic        pv_ff,        pv_in;
   logic        end_ff,       end_in;
   logic [15:0] cc_ff,        cc_in;
   logic [15:0] ww_ff,        ww_in;

   logic                  req_fire;
   logic                  emit;
   logic                  complete;
   logic [2:0]            n_follow;
   logic [31:0]           value;
   logic [1:0]            ex_idx;
   logic                  words_full;
   logic [EXT_W-1:0]      consumed_ext;
   logic [EXT_W-1:0]      words_ext;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   // Word limit compare at a common width
   assign words_full = ({16'd0, words_ff} >= {{COUNT_BITS{1'b0}}, max_words_ff});
   assign n_follow   = follow_count(req_data_byte);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff      <= 1'b0;
         max_words_ff <= 16'hFFFF;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SWAP_OUTPUT: swap_ff      <= csr_wdata[0];
            CSR_MAX_WORDS:   max_words_ff <= csr_wdata[15:0];
            default:         swap_ff      <= swap_ff;
         endcase
      end
   end

   // Decode step for one byte
   always_comb begin
      pending_in  = pending_ff;
      seq_len_in  = seq_len_ff;
      acc_in      = acc_ff;
      discard_in  = discard_ff;
      halted_in   = halted_ff;
      consumed_in = consumed_ff;
      words_in    = words_ff;
      complete    = 1'b0;
      value       = 32'd0;
      ex_idx      = 2'd0;
      pv_in       = 1'b0;

      if (!halted_ff) begin
         if (pending_ff == 3'd0) begin
            if (words_full) begin
               halted_in = 1'b1;
            end else begin
               seq_len_in = n_follow + 3'd1;
               pending_in = n_follow;
               discard_in = (n_follow >= 3'd4);
               acc_in     = {24'd0, req_data_byte};
               complete   = (n_follow == 3'd0);
            end
         end else begin
            if (!discard_ff) begin
               acc_in = {acc_ff[25:0], 6'd0} + {24'd0, req_data_byte};
            end
            pending_in = pending_ff - 3'd1;
            complete   = (pending_in == 3'd0);
         end
      end

      // Sequence done: count bytes, strip excess, emit nonzero word
      if (complete) begin
         consumed_in = consumed_ff + {{(COUNT_BITS-3){1'b0}}, seq_len_in};
         if (!discard_in) begin
            ex_idx = 2'(seq_len_in - 3'd1);
            value  = acc_in - excess(ex_idx);
            if (value != 32'd0) begin
               pv_in    = 1'b1;
               words_in = words_ff + {{(COUNT_BITS-1){1'b0}}, 1'b1};
            end
         end
         discard_in = 1'b0;
         acc_in     = 32'd0;
      end

      emit         = pv_in || req_last;
      cp_in        = pv_in ? (swap_ff ? swap32(value) : value) : 32'd0;
      end_in       = req_last;
      consumed_ext = {16'd0, consumed_in};
      words_ext    = {16'd0, words_in};
      cc_in        = req_last ? consumed_ext[15:0] : 16'd0;
      ww_in        = req_last ? words_ext[15:0] : 16'd0;

      // End of buffer readies the next one
      if (req_last) begin
         pending_in  = 3'd0;
         seq_len_in  = 3'd0;
         acc_in      = 32'd0;
         discard_in  = 1'b0;
         halted_in   = 1'b0;
         consumed_in = '0;
         words_in    = '0;
      end

      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 3'd0;
         seq_len_ff   <= 3'd0;
         acc_ff       <= 32'd0;
         discard_ff   <= 1'b0;
         halted_ff    <= 1'b0;
         consumed_ff  <= '0;
         words_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            pending_ff  <= pending_in;
            seq_len_ff  <= seq_len_in;
            acc_ff      <= acc_in;
            discard_ff  <= discard_in;
            halted_ff   <= halted_in;
            consumed_ff <= consumed_in;
            words_ff    <= words_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         cp_ff  <= cp_in;
         pv_ff  <= pv_in;
         end_ff <= end_in;
         cc_ff  <= cc_in;
         ww_ff  <= ww_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_point     = cp_ff;
   assign rsp_point_valid    = pv_ff;
   assign rsp_end_report     = end_ff;
   assign rsp_consumed_count = cc_ff;
   assign rsp_words_written  = ww_ff;

   // Halting only happens between sequences
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> (pending_ff == 3'd0))
      else $error("halted with a sequence in flight");

   // Discarded runs come only from long leads
   a_discard_len: assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> (seq_len_ff >= 3'd5))
      else $error("discard flag on a short sequence");

   // Pending continuation bytes stay below the sequence length
   a_pending_len: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 3'd0) |-> (pending_ff < seq_len_ff))
      else $error("pending count exceeds sequence length");

   // A last byte clears the buffer state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last) |=>
         (consumed_ff == '0 && words_ff == '0 && !halted_ff && pending_ff == 3'd0))
      else $error("buffer state not cleared after last byte");

   // A valid word is never zero
   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && pv_ff) |-> (cp_ff != 32'd0))
      else $error("zero code point flagged valid");

endmodule
